@@ hdl/ftq_pkg.sv @@
// ftq_pkg: shared constants, codes and beat types of the fixed-interval sleep timer queues.
// No dependencies; used by ftq_div and fixed_interval_sleep_timer_queues.
package ftq_pkg;

	// sizing
	localparam int CLASS_COUNT  = 4;
	localparam int QUEUE_DEPTH  = 16;
	localparam int REG_COUNT    = 4;
	localparam int LIVE_CLASSES = (CLASS_COUNT < REG_COUNT) ? CLASS_COUNT : REG_COUNT;
	localparam int NS_PER_US    = 1000;

	// fixed field widths
	localparam int NOW_W      = 64;
	localparam int TASK_W     = 16;
	localparam int CLASS_W    = 2;
	localparam int EL_W       = 55;
	localparam int INTERVAL_W = 32;
	localparam int REG_IW     = 2;

	// derived widths
	localparam int PTR_W   = $clog2(QUEUE_DEPTH);
	localparam int OCC_W   = $clog2(QUEUE_DEPTH + 1);
	localparam int CLS_IW  = (CLASS_COUNT > 1) ? $clog2(CLASS_COUNT) : 1;
	localparam int CIDX_W  = $clog2(LIVE_CLASSES + 1);
	localparam int SLOTS   = CLASS_COUNT * QUEUE_DEPTH;
	localparam int SLOT_W  = $clog2(SLOTS);
	localparam int SPAN_W  = INTERVAL_W + $clog2(NS_PER_US);
	localparam int REM_W   = $clog2(NS_PER_US);

	// divide by NS_PER_US one digit at a time: digit value = remainder:chunk,
	// quotient digit = (value * DIV_RECIP) >> DIV_SHIFT, exact for every value below 2**DIV_V_W
	localparam int     DIV_CHUNK_W = 16;
	localparam int     DIV_CHUNKS  = NOW_W / DIV_CHUNK_W;
	localparam int     DIV_CNT_W   = $clog2(DIV_CHUNKS);
	localparam int     DIV_V_W     = REM_W + DIV_CHUNK_W;
	localparam int     DIV_SHIFT   = DIV_V_W + REM_W;
	localparam int     DIV_M_W     = DIV_SHIFT - REM_W + 1;
	localparam int     DIV_PROD_W  = DIV_V_W + DIV_M_W;
	localparam longint DIV_RECIP   =
		((longint'(1) << DIV_SHIFT) + longint'(NS_PER_US) - 1) / longint'(NS_PER_US);

	typedef logic [PTR_W-1:0]      ptr_t;
	typedef logic [OCC_W-1:0]      occ_t;
	typedef logic [CLS_IW-1:0]     cls_idx_t;
	typedef logic [CIDX_W-1:0]     cidx_t;
	typedef logic [SLOT_W-1:0]     slot_t;
	typedef logic [SPAN_W-1:0]     span_t;
	typedef logic [NOW_W:0]        wsum_t;
	typedef logic [NOW_W-1:0]      now_t;
	typedef logic [CLASS_W-1:0]    class_t;
	typedef logic [REG_IW-1:0]     reg_idx_t;
	typedef logic [INTERVAL_W-1:0] interval_t;
	typedef logic [EL_W-1:0]       elapsed_t;
	typedef logic [DIV_CHUNK_W-1:0] div_chunk_t;
	typedef logic [DIV_V_W-1:0]    div_dig_t;
	typedef logic [DIV_PROD_W-1:0] div_prod_t;

	// command codes
	localparam logic CMD_ENQ  = 1'b0;
	localparam logic CMD_POLL = 1'b1;

	// result kinds
	localparam logic [1:0] KIND_ENQ   = 2'd0;
	localparam logic [1:0] KIND_FULL  = 2'd1;
	localparam logic [1:0] KIND_WOKEN = 2'd2;
	localparam logic [1:0] KIND_NONE  = 2'd3;

	// interval registers after reset (100 ms, 1 s, 10 s, 60 s)
	localparam interval_t INTERVAL_RST [REG_COUNT] = '{
		interval_t'(100 * 1000),
		interval_t'(1000 * 1000),
		interval_t'(10 * 1000 * 1000),
		interval_t'(60 * 1000 * 1000)
	};

	typedef struct packed {
		logic              cmd;
		logic [1:0]        interval_class;
		logic [TASK_W-1:0] task_id;
		logic [NOW_W-1:0]  now_ns;
	} item_t;

	typedef struct packed {
		logic [1:0]        kind;
		logic [TASK_W-1:0] woken_task;
		logic [1:0]        woken_class;
		logic [EL_W-1:0]   elapsed_us;
		logic              last;
	} result_t;

endpackage

@@ hdl/ftq_div.sv @@
// ftq_div: divides a 64-bit time span by NS_PER_US, one 16-bit digit at a time, first the
// quotient digit by reciprocal multiplication, then the remainder. Depends on ftq_pkg.
module ftq_div (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   load,
	input  ftq_pkg::now_t          dividend,
	output logic                   done,
	output ftq_pkg::elapsed_t      quotient
);

	logic [ftq_pkg::NOW_W-1:0]     acc_q;     // dividend digits, most significant on top
	logic [ftq_pkg::NOW_W-1:0]     quo_q;     // quotient digits shift in from the bottom
	logic [ftq_pkg::REM_W-1:0]     rem_q;
	logic [ftq_pkg::DIV_CNT_W-1:0] cnt_q;
	logic                          phase_q;   // 0: quotient digit, 1: remainder
	logic                          run_q;
	logic                          done_q;
	ftq_pkg::div_chunk_t           qd_q;
	ftq_pkg::div_dig_t             dig;
	ftq_pkg::div_prod_t            prod;
	ftq_pkg::div_dig_t             back;

	assign dig  = {rem_q, acc_q[ftq_pkg::NOW_W-1 -: ftq_pkg::DIV_CHUNK_W]};
	assign prod = ftq_pkg::div_prod_t'(dig) * ftq_pkg::div_prod_t'(ftq_pkg::DIV_RECIP);
	assign back = dig - ftq_pkg::div_dig_t'(qd_q) * ftq_pkg::div_dig_t'(ftq_pkg::NS_PER_US);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q   <= 1'b0;
			done_q  <= 1'b0;
			phase_q <= 1'b0;
			cnt_q   <= '0;
		end else if (load) begin
			run_q   <= 1'b1;
			done_q  <= 1'b0;
			phase_q <= 1'b0;
			cnt_q   <= '0;
		end else if (run_q) begin
			phase_q <= ~phase_q;
			if (phase_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == ftq_pkg::DIV_CNT_W'(ftq_pkg::DIV_CHUNKS - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end else begin
					done_q <= 1'b0;
				end
			end else begin
				done_q <= 1'b0;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			acc_q <= dividend;
			rem_q <= '0;
		end else if (run_q) begin
			if (!phase_q) begin
				qd_q <= prod[ftq_pkg::DIV_SHIFT +: ftq_pkg::DIV_CHUNK_W];
			end else begin
				rem_q <= back[ftq_pkg::REM_W-1:0];
				acc_q <= acc_q << ftq_pkg::DIV_CHUNK_W;
				quo_q <= {quo_q[ftq_pkg::NOW_W-ftq_pkg::DIV_CHUNK_W-1:0], qd_q};
			end
		end
	end

	assign done     = done_q;
	assign quotient = quo_q[ftq_pkg::EL_W-1:0];

endmodule

@@ hdl/fixed_interval_sleep_timer_queues.sv @@
// fixed_interval_sleep_timer_queues: top level, sequencer, queue pointers and entry memory.
// Depends on ftq_pkg and ftq_div.
//
// Four FIFO sleep queues, one per interval class, sixteen entries each. A command
// beat is taken when start is high and busy is low; busy then stays high until
// the last result beat for that command has been put out. Results appear on
// result for exactly one cycle each, flagged by strobe, and cannot be held off:
// the receiver must take every strobe. result.last marks the final beat of a
// command. An enqueue gives one beat (enqueued); a drop on a full queue gives
// one beat (full). A poll that is not yet due, or finds every queue empty,
// gives one "nothing woken" beat. A due poll walks the classes in order:
// empty classes are skipped, a head that has not yet expired closes its class,
// and each woken task waits for the shared divider that turns the elapsed
// nanoseconds into microseconds (four 16-bit digits); a closing step sends the
// final beat. Each head's wakeup time is formed by one 32x10 multiply and one
// saturating 64-bit add, both stepped through the same sequencer. Interval
// registers are written through cfg_we / cfg_index / cfg_data with no wait
// state; the user must write them only while the block is not busy, which the
// block itself does not enforce. A poll uses the interval values in effect at
// that poll.
module fixed_interval_sleep_timer_queues (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	output logic                     busy,
	input  ftq_pkg::item_t           item,
	output logic                     strobe,
	output ftq_pkg::result_t         result,
	input  logic                     cfg_we,
	input  ftq_pkg::reg_idx_t        cfg_index,
	input  ftq_pkg::interval_t       cfg_data
);

	// sequencer states
	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_ENQ  = 4'd1;   // check room, write entry
	localparam logic [3:0] ST_MUL  = 4'd2;   // span = interval * 1000
	localparam logic [3:0] ST_ADD  = 4'd3;   // wake = start + span, saturated
	localparam logic [3:0] ST_ECMP = 4'd4;   // lower earliest wakeup, answer
	localparam logic [3:0] ST_PCHK = 4'd5;   // is the poll due at all
	localparam logic [3:0] ST_PCLS = 4'd6;   // walk classes
	localparam logic [3:0] ST_PCMP = 4'd7;   // head expired?
	localparam logic [3:0] ST_PDIV = 4'd8;   // wait for elapsed_us

	typedef struct packed {
		logic [ftq_pkg::TASK_W-1:0] task_id;
		logic [ftq_pkg::NOW_W-1:0]  start_ns;
	} entry_t;

	logic [3:0]           state_q;
	ftq_pkg::item_t       item_q;
	ftq_pkg::cidx_t       work_cls_q;
	ftq_pkg::interval_t   interval_q [ftq_pkg::REG_COUNT];
	ftq_pkg::ptr_t        head_q     [ftq_pkg::CLASS_COUNT];
	ftq_pkg::ptr_t        tail_q     [ftq_pkg::CLASS_COUNT];
	ftq_pkg::occ_t        occ_q      [ftq_pkg::CLASS_COUNT];
	ftq_pkg::now_t        earliest_q;
	ftq_pkg::span_t       span_q;
	ftq_pkg::now_t        wake_q;
	logic [ftq_pkg::TASK_W-1:0] task_q;
	ftq_pkg::result_t     result_q;
	logic                 strobe_q;
	ftq_pkg::result_t     pend_q;     // held woken beat, sent once its successor is known
	logic                 pend_v_q;

	entry_t               mem_q [ftq_pkg::SLOTS];
	entry_t               rd_q;

	ftq_pkg::cls_idx_t    cur;
	ftq_pkg::reg_idx_t    cur_reg;
	ftq_pkg::slot_t       rd_addr;
	ftq_pkg::slot_t       wr_addr;
	logic                 mem_we;
	logic                 enq_live;
	logic                 enq_full;
	logic                 any_pending;
	logic                 occ_over;
	ftq_pkg::now_t        add_start;
	ftq_pkg::wsum_t       wake_sum;
	logic                 div_load;
	logic                 div_done;
	ftq_pkg::elapsed_t    div_q;

	function automatic ftq_pkg::slot_t slot_of(ftq_pkg::cls_idx_t c, ftq_pkg::ptr_t p);
		return ftq_pkg::slot_t'(int'(c) * ftq_pkg::QUEUE_DEPTH + int'(p));
	endfunction

	function automatic ftq_pkg::ptr_t ptr_inc(ftq_pkg::ptr_t p);
		return (p == ftq_pkg::ptr_t'(ftq_pkg::QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	assign cur      = ftq_pkg::cls_idx_t'(work_cls_q);
	assign cur_reg  = ftq_pkg::reg_idx_t'(work_cls_q);
	assign rd_addr  = slot_of(cur, head_q[cur]);
	assign wr_addr  = slot_of(cur, tail_q[cur]);
	assign enq_live = (int'(item_q.interval_class) < ftq_pkg::LIVE_CLASSES);
	assign enq_full = (occ_q[cur] == ftq_pkg::occ_t'(ftq_pkg::QUEUE_DEPTH));
	assign mem_we   = (state_q == ST_ENQ) && enq_live && !enq_full;

	// enqueue takes its start time from the item, a poll from the head entry
	assign add_start = (item_q.cmd == ftq_pkg::CMD_ENQ) ? item_q.now_ns : rd_q.start_ns;
	assign wake_sum  = ftq_pkg::wsum_t'(add_start) + ftq_pkg::wsum_t'(span_q);

	assign div_load = (state_q == ST_PCMP) && (wake_q <= item_q.now_ns);

	always_comb begin
		any_pending = 1'b0;
		occ_over    = 1'b0;
		for (int i = 0; i < ftq_pkg::LIVE_CLASSES; i++) begin
			if (occ_q[i] != '0)
				any_pending = 1'b1;
			if (occ_q[i] > ftq_pkg::occ_t'(ftq_pkg::QUEUE_DEPTH))
				occ_over = 1'b1;
		end
	end

	ftq_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (div_load),
		.dividend (item_q.now_ns - rd_q.start_ns),
		.done     (div_done),
		.quotient (div_q)
	);

	// entry memory: one write port, one registered read port at the current head
	always_ff @(posedge clk) begin
		if (mem_we)
			mem_q[wr_addr] <= '{task_id: item_q.task_id, start_ns: item_q.now_ns};
		rd_q <= mem_q[rd_addr];
	end

	// interval registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < ftq_pkg::REG_COUNT; i++)
				interval_q[i] <= ftq_pkg::INTERVAL_RST[i];
		end else if (cfg_we && (int'(cfg_index) < ftq_pkg::REG_COUNT)) begin
			interval_q[cfg_index] <= cfg_data;
		end
	end

	// sequencer and queue control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			strobe_q   <= 1'b0;
			pend_v_q   <= 1'b0;
			work_cls_q <= '0;
			earliest_q <= '1;
			for (int i = 0; i < ftq_pkg::CLASS_COUNT; i++) begin
				head_q[i] <= '0;
				tail_q[i] <= '0;
				occ_q[i]  <= '0;
			end
		end else begin
			strobe_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						if (item.cmd == ftq_pkg::CMD_ENQ) begin
							state_q    <= ST_ENQ;
							work_cls_q <= ftq_pkg::cidx_t'(item.interval_class);
						end else begin
							state_q    <= ST_PCHK;
							work_cls_q <= '0;
						end
					end
				end
				ST_ENQ: begin
					if (!enq_live || enq_full) begin
						strobe_q <= 1'b1;
						state_q  <= ST_IDLE;
					end else begin
						tail_q[cur] <= ptr_inc(tail_q[cur]);
						occ_q[cur]  <= occ_q[cur] + 1'b1;
						state_q     <= ST_MUL;
					end
				end
				ST_MUL: begin
					state_q <= ST_ADD;
				end
				ST_ADD: begin
					state_q <= (item_q.cmd == ftq_pkg::CMD_ENQ) ? ST_ECMP : ST_PCMP;
				end
				ST_ECMP: begin
					if (wake_q < earliest_q)
						earliest_q <= wake_q;
					strobe_q <= 1'b1;
					state_q  <= ST_IDLE;
				end
				ST_PCHK: begin
					if (!any_pending || (item_q.now_ns < earliest_q)) begin
						strobe_q <= 1'b1;
						state_q  <= ST_IDLE;
					end else begin
						earliest_q <= '1;
						state_q    <= ST_PCLS;
					end
				end
				ST_PCLS: begin
					if (work_cls_q == ftq_pkg::cidx_t'(ftq_pkg::LIVE_CLASSES)) begin
						strobe_q <= 1'b1;
						pend_v_q <= 1'b0;
						state_q  <= ST_IDLE;
					end else if (occ_q[cur] == '0) begin
						work_cls_q <= work_cls_q + 1'b1;
					end else begin
						state_q <= ST_MUL;
					end
				end
				ST_PCMP: begin
					if (div_load) begin
						head_q[cur] <= ptr_inc(head_q[cur]);
						occ_q[cur]  <= occ_q[cur] - 1'b1;
						state_q     <= ST_PDIV;
					end else begin
						if (wake_q < earliest_q)
							earliest_q <= wake_q;
						work_cls_q <= work_cls_q + 1'b1;
						state_q    <= ST_PCLS;
					end
				end
				ST_PDIV: begin
					if (div_done) begin
						if (pend_v_q)
							strobe_q <= 1'b1;
						pend_v_q <= 1'b1;
						state_q  <= ST_PCLS;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if ((state_q == ST_IDLE) && start)
			item_q <= item;
		if (state_q == ST_MUL)
			span_q <= ftq_pkg::span_t'(interval_q[cur_reg]) *
			          ftq_pkg::span_t'(ftq_pkg::NS_PER_US);
		if (state_q == ST_ADD)
			wake_q <= wake_sum[ftq_pkg::NOW_W] ? '1 : wake_sum[ftq_pkg::NOW_W-1:0];
		if (div_load)
			task_q <= rd_q.task_id;
		if ((state_q == ST_PDIV) && div_done) begin
			result_q <= pend_q;
			pend_q   <= '{kind: ftq_pkg::KIND_WOKEN, woken_task: task_q,
			              woken_class: ftq_pkg::class_t'(work_cls_q), elapsed_us: div_q,
			              last: 1'b0};
		end
		case (state_q)
			ST_ENQ: begin
				result_q <= '{kind: ftq_pkg::KIND_FULL, woken_task: '0,
				              woken_class: item_q.interval_class, elapsed_us: '0, last: 1'b1};
			end
			ST_ECMP: begin
				result_q <= '{kind: ftq_pkg::KIND_ENQ, woken_task: '0,
				              woken_class: item_q.interval_class, elapsed_us: '0, last: 1'b1};
			end
			ST_PCHK: begin
				result_q <= '{kind: ftq_pkg::KIND_NONE, woken_task: '0,
				              woken_class: '0, elapsed_us: '0, last: 1'b1};
			end
			ST_PCLS: begin
				if (pend_v_q) begin
					result_q <= '{kind: pend_q.kind, woken_task: pend_q.woken_task,
					              woken_class: pend_q.woken_class,
					              elapsed_us: pend_q.elapsed_us, last: 1'b1};
				end else begin
					result_q <= '{kind: ftq_pkg::KIND_NONE, woken_task: '0,
					              woken_class: '0, elapsed_us: '0, last: 1'b1};
				end
			end
			default: begin
			end
		endcase
	end

	assign busy   = (state_q != ST_IDLE);
	assign strobe = strobe_q;
	assign result = result_q;

	// checks
	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n) !occ_over)
		else $error("queue occupancy above depth");

	a_strobe_busy: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> $past(busy))
		else $error("result beat without a command in flight");

	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && result.last |-> !busy)
		else $error("final beat while still busy");

	a_mid_busy: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !result.last |-> busy && (result.kind == ftq_pkg::KIND_WOKEN))
		else $error("non-final beat that is not a woken task");

	a_div_wait: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == ST_PDIV))
		else $error("divider finished outside its wait state");

endmodule

@@ tb/fixed_interval_sleep_timer_queues_tb.sv @@
// Testbench of fixed_interval_sleep_timer_queues: directed and random sleep/poll beats,
// checked against a behavioral copy of the four interval queues kept in this file.
// Depends on ftq_pkg and the block's RTL only.
`timescale 1ns / 100ps

module fixed_interval_sleep_timer_queues_tb;

	localparam int            LIMIT_CYCLES = 2_000_000;
	localparam int            SHOW_FAULTS  = 10;
	localparam int            SETTLE       = 8;   // margin past the longest single-beat command
	localparam ftq_pkg::now_t NEVER        = '1;  // wakeup register value with no sleeper pending

	logic                 clk;
	logic                 arst_n;
	logic                 start;
	logic                 busy;
	ftq_pkg::item_t       item;
	logic                 strobe;
	ftq_pkg::result_t     result;
	logic                 cfg_we;
	ftq_pkg::reg_idx_t    cfg_index;
	ftq_pkg::interval_t   cfg_data;

	fixed_interval_sleep_timer_queues i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.item      (item),
		.strobe    (strobe),
		.result    (result),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #10 clk = ~clk;

	// ------------------------------------------------------------------
	// Behavioral copy of the sleep queues: interval registers, per-class
	// ring buffers of (task, start time) and the earliest-wakeup register.
	// ------------------------------------------------------------------
	ftq_pkg::interval_t         ival      [ftq_pkg::REG_COUNT];
	logic [ftq_pkg::TASK_W-1:0] slot_task [ftq_pkg::CLASS_COUNT][ftq_pkg::QUEUE_DEPTH];
	ftq_pkg::now_t              slot_t0   [ftq_pkg::CLASS_COUNT][ftq_pkg::QUEUE_DEPTH];
	int                         rd_ptr    [ftq_pkg::CLASS_COUNT];
	int                         wr_ptr    [ftq_pkg::CLASS_COUNT];
	int                         fill      [ftq_pkg::CLASS_COUNT];
	ftq_pkg::now_t              soonest_ns;

	ftq_pkg::result_t wake_beats[$];   // beats the last command produces, in order
	ftq_pkg::result_t awaited[$];      // beats still owed by the block, oldest first

	// stimulus state
	int            idle_pct;
	ftq_pkg::now_t clock_ns;           // running time base of the well-formed random traffic

	// checking state
	int               fault_count;
	int               cycle_count;
	ftq_pkg::result_t oldest;

	typedef struct {
		ftq_pkg::item_t   it;
		bit               typed;       // expected beat written out in the row itself
		ftq_pkg::result_t beat;
	} row_t;
	row_t plan[$];

	// Start plus the class interval, saturating at all ones.
	function automatic ftq_pkg::now_t wake_at(input int c, input ftq_pkg::now_t t0);
		ftq_pkg::now_t span;
		span = ftq_pkg::now_t'(ival[c]) * ftq_pkg::now_t'(ftq_pkg::NS_PER_US);
		if (t0 > NEVER - span)
			return NEVER;
		return t0 + span;
	endfunction

	// Apply one accepted command to the queue copy and fill wake_beats.
	task automatic compute_wakeups(input ftq_pkg::item_t it);
		ftq_pkg::result_t r;
		ftq_pkg::result_t held;
		bit               have;
		bit               any;
		bit               stop;
		int               c;
		ftq_pkg::now_t    st;
		ftq_pkg::now_t    w;
		wake_beats.delete();
		r      = '0;
		r.last = 1'b1;
		if (it.cmd == ftq_pkg::CMD_ENQ) begin
			c             = int'(it.interval_class);
			r.woken_class = it.interval_class;
			if (c >= ftq_pkg::LIVE_CLASSES || fill[c] >= ftq_pkg::QUEUE_DEPTH) begin
				r.kind = ftq_pkg::KIND_FULL;
			end else begin
				slot_task[c][wr_ptr[c]] = it.task_id;
				slot_t0[c][wr_ptr[c]]   = it.now_ns;
				wr_ptr[c]               = (wr_ptr[c] + 1) % ftq_pkg::QUEUE_DEPTH;
				fill[c]++;
				w = wake_at(c, it.now_ns);
				if (w < soonest_ns)
					soonest_ns = w;
				r.kind = ftq_pkg::KIND_ENQ;
			end
			wake_beats.push_back(r);
		end else begin
			any = 1'b0;
			for (c = 0; c < ftq_pkg::LIVE_CLASSES; c++)
				if (fill[c] != 0)
					any = 1'b1;
			r.kind = ftq_pkg::KIND_NONE;
			if (!any || it.now_ns < soonest_ns) begin
				wake_beats.push_back(r);
			end else begin
				// due: pop expired heads class by class, rebuild the wakeup register
				soonest_ns = NEVER;
				have       = 1'b0;
				held       = '0;
				for (c = 0; c < ftq_pkg::LIVE_CLASSES; c++) begin
					stop = 1'b0;
					while (fill[c] != 0 && !stop) begin
						st = slot_t0[c][rd_ptr[c]];
						w  = wake_at(c, st);
						if (w <= it.now_ns) begin
							// hold one beat back so the final one can carry last
							if (have)
								wake_beats.push_back(held);
							held             = '0;
							held.kind        = ftq_pkg::KIND_WOKEN;
							held.woken_task  = slot_task[c][rd_ptr[c]];
							held.woken_class = ftq_pkg::class_t'(c);
							held.elapsed_us  = ftq_pkg::elapsed_t'((it.now_ns - st) /
								ftq_pkg::now_t'(ftq_pkg::NS_PER_US));
							have             = 1'b1;
							rd_ptr[c]        = (rd_ptr[c] + 1) % ftq_pkg::QUEUE_DEPTH;
							fill[c]--;
						end else begin
							if (w < soonest_ns)
								soonest_ns = w;
							stop = 1'b1;
						end
					end
				end
				if (have) begin
					held.last = 1'b1;
					wake_beats.push_back(held);
				end else begin
					wake_beats.push_back(r);   // due but nothing had expired yet
				end
			end
		end
	endtask

	// ------------------------------------------------------------------
	// Command side
	// ------------------------------------------------------------------

	// Present one command, wait for the handshake, book its beats, then maybe idle.
	task automatic send_command(input ftq_pkg::item_t it, input bit typed,
			input ftq_pkg::result_t beat);
		item  <= it;
		start <= 1'b1;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		compute_wakeups(it);
		if (typed)
			awaited.push_back(beat);
		else
			foreach (wake_beats[k])
				awaited.push_back(wake_beats[k]);
		// geometric idle gap; start is only dropped when a gap is taken
		if ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			do
				@(posedge clk);
			while ($urandom_range(99) < idle_pct);
		end
	endtask

	task automatic add_row(input ftq_pkg::item_t it, input bit typed,
			input ftq_pkg::result_t beat);
		row_t r;
		r.it    = it;
		r.typed = typed;
		r.beat  = beat;
		plan.push_back(r);
	endtask

	// Most traffic follows a running clock so sleepers expire naturally; a few
	// commands carry a fully random time stamp to exercise the upper bits and
	// the saturation paths.
	function automatic ftq_pkg::item_t random_item();
		ftq_pkg::item_t it;
		it.cmd            = ($urandom_range(99) < 55) ? ftq_pkg::CMD_ENQ : ftq_pkg::CMD_POLL;
		it.interval_class = 2'($urandom_range(3));
		it.task_id        = 16'($urandom);
		if ($urandom_range(99) < 6) begin
			it.now_ns = {$urandom, $urandom};
		end else begin
			if (clock_ns < 64'hFFFF_FFFF_FFFF_0000)
				clock_ns += ftq_pkg::now_t'($urandom_range(12000));
			it.now_ns = clock_ns;
		end
		return it;
	endfunction

	task automatic random_phase(input int count, input int pct, input ftq_pkg::now_t base);
		idle_pct = pct;
		clock_ns = base;
		repeat (count)
			send_command(random_item(), 1'b0, '0);
	endtask

	// Let every owed beat arrive and the block fall idle.
	task automatic drain();
		start <= 1'b0;
		while (awaited.size() != 0 || busy)
			@(posedge clk);
		repeat (SETTLE)
			@(posedge clk);
	endtask

	// Write all four interval registers, one per cycle; only called while idle.
	task automatic load_intervals(input ftq_pkg::interval_t v0, input ftq_pkg::interval_t v1,
			input ftq_pkg::interval_t v2, input ftq_pkg::interval_t v3);
		ftq_pkg::interval_t vals [ftq_pkg::REG_COUNT];
		vals = '{v0, v1, v2, v3};
		for (int i = 0; i < ftq_pkg::REG_COUNT; i++) begin
			cfg_we    <= 1'b1;
			cfg_index <= ftq_pkg::reg_idx_t'(i);
			cfg_data  <= vals[i];
			@(posedge clk);
			ival[i] = vals[i];
		end
		cfg_we <= 1'b0;
	endtask

	// ------------------------------------------------------------------
	// Result side: every strobe is a beat that must match the oldest owed one
	// ------------------------------------------------------------------
	task automatic note_fault(input string what, input ftq_pkg::result_t want,
			input ftq_pkg::result_t got);
		fault_count++;
		if (fault_count <= SHOW_FAULTS)
			$display({"%0t %s: expected kind %0d task %h class %0d elapsed %0d last %0d,",
				" got kind %0d task %h class %0d elapsed %0d last %0d"},
				$realtime, what,
				want.kind, want.woken_task, want.woken_class, want.elapsed_us, want.last,
				got.kind, got.woken_task, got.woken_class, got.elapsed_us, got.last);
	endtask

	always @(posedge clk) begin
		if (arst_n && strobe) begin
			if (awaited.size() == 0) begin
				note_fault("beat with nothing owed", '0, result);
			end else begin
				oldest = awaited.pop_front();
				if (result.kind !== oldest.kind || result.woken_task !== oldest.woken_task ||
						result.woken_class !== oldest.woken_class ||
						result.elapsed_us !== oldest.elapsed_us || result.last !== oldest.last)
					note_fault("beat mismatch", oldest, result);
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= LIMIT_CYCLES) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------
	initial begin
		clk         = 1'b0;
		arst_n      = 1'b0;
		start       = 1'b0;
		item        = '0;
		cfg_we      = 1'b0;
		cfg_index   = '0;
		cfg_data    = '0;
		fault_count = 0;
		cycle_count = 0;
		idle_pct    = 12;
		clock_ns    = '0;

		// queue copy after reset
		ival       = ftq_pkg::INTERVAL_RST;
		soonest_ns = NEVER;
		for (int c = 0; c < ftq_pkg::CLASS_COUNT; c++) begin
			rd_ptr[c] = 0;
			wr_ptr[c] = 0;
			fill[c]   = 0;
		end

		repeat (12)
			@(posedge clk);
		@(negedge clk) arst_n = 1'b1;
		@(posedge clk);

		// Directed rows, reset intervals (class 0 sleeps 100 ms).
		// Empty poll, then one class 0 sleeper that is one ns short, then exactly due.
		add_row('{ftq_pkg::CMD_POLL, 2'd0, 16'd0, 64'd0}, 1'b1,
			'{ftq_pkg::KIND_NONE, 16'd0, 2'd0, 55'd0, 1'b1});
		add_row('{ftq_pkg::CMD_ENQ, 2'd0, 16'hFFFF, 64'd0}, 1'b1,
			'{ftq_pkg::KIND_ENQ, 16'd0, 2'd0, 55'd0, 1'b1});
		add_row('{ftq_pkg::CMD_POLL, 2'd0, 16'd0, 64'd99_999_999}, 1'b1,
			'{ftq_pkg::KIND_NONE, 16'd0, 2'd0, 55'd0, 1'b1});
		add_row('{ftq_pkg::CMD_POLL, 2'd0, 16'd0, 64'd100_000_000}, 1'b1,
			'{ftq_pkg::KIND_WOKEN, 16'hFFFF, 2'd0, 55'd100_000, 1'b1});
		// fill class 1, then one more is dropped as full
		for (int i = 0; i < ftq_pkg::QUEUE_DEPTH; i++)
			add_row('{ftq_pkg::CMD_ENQ, 2'd1, 16'(i), 64'd100_000_000 + 64'(i)}, 1'b1,
				'{ftq_pkg::KIND_ENQ, 16'd0, 2'd1, 55'd0, 1'b1});
		add_row('{ftq_pkg::CMD_ENQ, 2'd1, 16'h1234, 64'd150_000_000}, 1'b1,
			'{ftq_pkg::KIND_FULL, 16'd0, 2'd1, 55'd0, 1'b1});
		// class 3 sleeper whose wakeup saturates; poll at the end of time wakes all
		add_row('{ftq_pkg::CMD_ENQ, 2'd2, 16'd0, 64'd200_000_000}, 1'b0, '0);
		add_row('{ftq_pkg::CMD_ENQ, 2'd3, 16'h8000, 64'hFFFF_FFFF_FFFF_FF00}, 1'b0, '0);
		add_row('{ftq_pkg::CMD_POLL, 2'd0, 16'd0, NEVER}, 1'b0, '0);
		// wakeup register stuck at all ones with a sleeper pending
		add_row('{ftq_pkg::CMD_ENQ, 2'd0, 16'd5, NEVER}, 1'b1,
			'{ftq_pkg::KIND_ENQ, 16'd0, 2'd0, 55'd0, 1'b1});
		add_row('{ftq_pkg::CMD_POLL, 2'd0, 16'd0, NEVER - 64'd1}, 1'b1,
			'{ftq_pkg::KIND_NONE, 16'd0, 2'd0, 55'd0, 1'b1});
		add_row('{ftq_pkg::CMD_POLL, 2'd0, 16'd0, NEVER}, 1'b1,
			'{ftq_pkg::KIND_WOKEN, 16'd5, 2'd0, 55'd0, 1'b1});

		foreach (plan[i])
			send_command(plan[i].it, plan[i].typed, plan[i].beat);
		drain();

		// short intervals, zero among them: sleepers expire within a few beats
		load_intervals(32'd0, 32'd3, 32'd10, 32'd25);
		random_phase(70, 12, '0);
		drain();

		// random short intervals from a random time base; sender idles often
		load_intervals(ftq_pkg::interval_t'($urandom_range(1, 60)),
			ftq_pkg::interval_t'($urandom_range(1, 60)),
			ftq_pkg::interval_t'($urandom_range(1, 60)),
			ftq_pkg::interval_t'($urandom_range(1, 60)));
		random_phase(65, 61, {$urandom, $urandom} >> 1);
		drain();

		// extremes near the top of the time range: class 0 never expires on its own
		load_intervals(32'hFFFF_FFFF, 32'd1, 32'd50, 32'd0);
		random_phase(65, 0, 64'hFFFF_FFFF_FFF0_0000);
		drain();

		if (fault_count == 0 && awaited.size() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
